// ===== design/twc_pkg.sv =====
// Package for the trigger window coalescer: types, codes and constants.
`timescale 1ns / 1ps
package twc_pkg;

  localparam int TableDepthDef = 16;
  localparam int NumTriggerIdsDef = 16;
  localparam int TimeBits = 48;

  localparam int IdW = 16;
  localparam int GrpW = 3;
  localparam int TidW = 4;
  localparam int CntW = 16;
  localparam logic [CntW-1:0] CntMax = '1;

  typedef enum logic [1:0] {
    MODE_REG = 2'd0,
    MODE_LIST = 2'd1,
    MODE_MARK = 2'd2,
    MODE_REMOVE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_ENTRY = 2'd0,
    ST_NONE = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_SHIFT,
    S_OUT
  } fsm_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic clr_idx;   // restart the walk at entry zero
    logic step;      // advance the walk
    logic apply;     // merge, create, or mark at the walk index
    logic emit;      // load output register from the walk index
    logic emit_none; // load output register with a no-entry result
    logic shift;     // copy entry idx+1 down to idx (remove compaction)
    logic drop_top;  // invalidate the last used entry
    logic out_last;  // last flag for this result
  } twc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;    // walk index reached used count
    logic hit;       // current entry qualifies for this mode
    logic full;      // table is full
    logic snap;      // request group is the snapshot group
    logic found;     // remove already located a matching entry
  } twc_sts_t;

endpackage

// ===== design/twc_ctrl.sv =====
// Controller state machine of the trigger window coalescer.
`timescale 1ns / 1ps
module twc_ctrl
  import twc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  mode_t    mode,
  input  twc_sts_t sts,
  input  logic     out_busy,
  output logic     in_ready,
  output twc_cmd_t cmd
);

  fsm_t state_r, state_nxt;
  logic [4:0] nres_r, nres_nxt;
  mode_t mode_r;

  // Capture the mode with the request.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nres_r <= '0;
    end else begin
      state_r <= state_nxt;
      nres_r <= nres_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    nres_nxt = nres_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_SCAN;
          nres_nxt = '0;
        end
      end
      S_SCAN: begin
        if (!out_busy) begin
          case (mode_r)
            MODE_REG: begin
              if (sts.at_end || (sts.hit && !sts.snap)) state_nxt = S_IDLE;
            end
            MODE_LIST: begin
              if (sts.at_end || nres_r == 5'd16) state_nxt = S_IDLE;
              else if (sts.hit) nres_nxt = nres_r + 5'd1;
            end
            MODE_MARK: begin
              if (sts.at_end || sts.hit) state_nxt = S_IDLE;
            end
            MODE_REMOVE: begin
              if (sts.at_end) state_nxt = S_IDLE;
              else if (sts.hit) state_nxt = S_SHIFT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_SHIFT: begin
        if (sts.at_end) state_nxt = S_SCAN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd = '0;
    in_ready = (state_r == S_IDLE);
    cmd.load = in_fire;
    cmd.clr_idx = in_fire;
    case (state_r)
      S_SCAN: begin
        if (!out_busy) begin
          case (mode_r)
            MODE_REG: begin
              if (sts.hit && !sts.snap) begin
                cmd.apply = 1'b1;
                cmd.emit = 1'b1;
                cmd.out_last = 1'b1;
              end else if (sts.at_end) begin
                if (sts.full) begin
                  cmd.emit_none = 1'b1;
                end else begin
                  cmd.apply = 1'b1;
                  cmd.emit = 1'b1;
                end
                cmd.out_last = 1'b1;
              end else begin
                cmd.step = 1'b1;
              end
            end
            MODE_LIST: begin
              if (sts.at_end || nres_r == 5'd16) begin
                if (nres_r == 5'd0) begin
                  cmd.emit_none = 1'b1;
                  cmd.out_last = 1'b1;
                end
              end else begin
                cmd.step = 1'b1;
              end
            end
            MODE_MARK: begin
              if (sts.hit) begin
                cmd.apply = 1'b1;
                cmd.emit = 1'b1;
                cmd.out_last = 1'b1;
              end else if (sts.at_end) begin
                cmd.emit_none = 1'b1;
                cmd.out_last = 1'b1;
              end else begin
                cmd.step = 1'b1;
              end
            end
            MODE_REMOVE: begin
              if (sts.at_end) begin
                if (!sts.found) begin
                  cmd.emit_none = 1'b1;
                  cmd.out_last = 1'b1;
                end
              end else if (sts.hit) begin
                if (!sts.found) begin
                  cmd.emit = 1'b1;
                  cmd.out_last = 1'b1;
                end
              end else begin
                cmd.step = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        if (sts.at_end) cmd.drop_top = 1'b1;
        else cmd.shift = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/twc_dp.sv =====
// Datapath of the trigger window coalescer: event table, walk index and result register.
`timescale 1ns / 1ps
module twc_dp
  import twc_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int NUM_TRIGGER_IDS = NumTriggerIdsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  twc_cmd_t              cmd,
  output twc_sts_t              sts,
  input  logic [GrpW-1:0]       snapshot_group,
  input  mode_t                 mode,
  input  logic [GrpW-1:0]       group,
  input  logic [TidW-1:0]       trigger_id,
  input  logic [TimeBits-1:0]   fire_tm,
  input  logic [TimeBits-1:0]   win_beg,
  input  logic [TimeBits-1:0]   win_end,
  input  logic [TimeBits-1:0]   cool_tm,
  input  logic [TimeBits-1:0]   now_tm,
  input  logic                  list_all,
  input  logic [IdW-1:0]        target_id,
  input  logic                  out_take,
  output logic                  out_valid,
  output logic [1:0]            res_status,
  output logic [IdW-1:0]        res_id,
  output logic [GrpW-1:0]       res_group,
  output logic [TimeBits-1:0]   res_first,
  output logic [TimeBits-1:0]   res_latest,
  output logic [TimeBits-1:0]   res_start,
  output logic [TimeBits-1:0]   res_stop,
  output logic [TimeBits-1:0]   res_ready,
  output logic [CntW-1:0]       res_tcnt,
  output logic [CntW-1:0]       res_rcnt,
  output logic                  res_last
);

  localparam int IdxW = $clog2(TABLE_DEPTH);
  localparam int UsedW = $clog2(TABLE_DEPTH + 1);
  localparam int SeenW = NUM_TRIGGER_IDS;
  localparam int SelW = (NUM_TRIGGER_IDS > 1) ? $clog2(NUM_TRIGGER_IDS) : 1;

  // Table storage; entries are packed at the low indices in insertion order.
  logic [TABLE_DEPTH-1:0] exp_r;
  logic [IdW-1:0]       id_r    [TABLE_DEPTH];
  logic [GrpW-1:0]      grp_r   [TABLE_DEPTH];
  logic [TimeBits-1:0]  first_r [TABLE_DEPTH];
  logic [TimeBits-1:0]  lat_r   [TABLE_DEPTH];
  logic [TimeBits-1:0]  start_r [TABLE_DEPTH];
  logic [TimeBits-1:0]  stop_r  [TABLE_DEPTH];
  logic [TimeBits-1:0]  rdy_r   [TABLE_DEPTH];
  logic [CntW-1:0]      tc_r    [TABLE_DEPTH];
  logic [CntW-1:0]      rc_r    [TABLE_DEPTH];
  logic [SeenW-1:0]     seen_r  [TABLE_DEPTH];
  logic [UsedW-1:0] used_r;
  logic [IdW-1:0] next_id_r;
  logic [UsedW-1:0] idx_r;
  logic found_r;

  // Captured request.
  mode_t q_mode_r;
  logic [GrpW-1:0] q_grp_r;
  logic [SelW-1:0] q_tid_r;
  logic [TimeBits-1:0] q_tt_r, q_bt_r, q_et_r, q_rdy_r, q_now_r;
  logic q_all_r;
  logic [IdW-1:0] q_tgt_r;

  // Saturating end plus cooldown.
  logic [TimeBits:0] rdy_sum;
  assign rdy_sum = {1'b0, win_end} + {1'b0, cool_tm};

  // Trigger id folded into the seen-bit range by a small table of constants.
  logic [SelW-1:0] tid_mod;
  always_comb begin
    tid_mod = '0;
    for (int v = 0; v < (1 << TidW); v++) begin
      if (trigger_id == TidW'(v)) tid_mod = SelW'(v % NUM_TRIGGER_IDS);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_mode_r <= mode;
      q_grp_r <= group;
      q_tid_r <= tid_mod;
      q_tt_r <= fire_tm;
      q_bt_r <= win_beg;
      q_et_r <= win_end;
      q_rdy_r <= rdy_sum[TimeBits] ? '1 : rdy_sum[TimeBits-1:0];
      q_now_r <= now_tm;
      q_all_r <= list_all;
      q_tgt_r <= target_id;
    end
  end

  // Current entry view.
  logic [IdxW-1:0] ci;
  logic [IdxW-1:0] cn;
  logic [IdxW-1:0] ct;
  assign ci = idx_r[IdxW-1:0];
  assign cn = IdxW'(idx_r + UsedW'(1));
  assign ct = IdxW'(used_r - UsedW'(1));

  logic at_end, ov, ro, reg_hit, hit;
  logic [SeenW-1:0] bit_sel;
  assign at_end = (idx_r == used_r);
  assign bit_sel = SeenW'(1) << q_tid_r;
  assign ov = (q_bt_r <= stop_r[ci]) && (q_et_r >= start_r[ci]);
  assign ro = (q_tt_r <= rdy_r[ci]) && (q_et_r >= start_r[ci]);
  assign reg_hit = !exp_r[ci] && (grp_r[ci] == q_grp_r) && (ov || ro);

  always_comb begin
    case (q_mode_r)
      MODE_REG: hit = reg_hit;
      MODE_LIST: hit = !exp_r[ci] && (q_all_r || q_now_r >= rdy_r[ci]);
      MODE_MARK: hit = (id_r[ci] == q_tgt_r);
      MODE_REMOVE: hit = (id_r[ci] == q_tgt_r);
      default: hit = 1'b0;
    endcase
  end

  assign sts.at_end = at_end;
  assign sts.hit = hit && !at_end;
  assign sts.full = (used_r == UsedW'(TABLE_DEPTH));
  assign sts.snap = (q_grp_r == snapshot_group);
  assign sts.found = found_r;

  // List emits every hit while stepping.
  logic list_emit;
  assign list_emit = cmd.step && (q_mode_r == MODE_LIST) && hit;

  // Merged values for the current entry.
  logic [CntW-1:0] m_tc, m_rc;
  assign m_tc = (tc_r[ci] != CntMax) ? tc_r[ci] + CntW'(1) : tc_r[ci];
  assign m_rc = (((seen_r[ci] & bit_sel) != '0) && rc_r[ci] != CntMax)
                ? rc_r[ci] + CntW'(1) : rc_r[ci];

  logic creating, merging;
  assign creating = cmd.apply && (q_mode_r == MODE_REG) && at_end;
  assign merging = cmd.apply && (q_mode_r == MODE_REG) && !at_end;

  // Control registers of the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      next_id_r <= '0;
      exp_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
    end else begin
      if (cmd.clr_idx) begin
        idx_r <= '0;
        found_r <= 1'b0;
      end else if (cmd.step) begin
        idx_r <= idx_r + UsedW'(1);
      end
      if (creating) begin
        used_r <= used_r + UsedW'(1);
        next_id_r <= next_id_r + IdW'(1);
        exp_r[ci] <= 1'b0;
      end
      if (cmd.apply && q_mode_r == MODE_MARK) exp_r[ci] <= 1'b1;
      if (cmd.emit && q_mode_r == MODE_REMOVE) found_r <= 1'b1;
      if (cmd.shift) begin
        exp_r[ci] <= exp_r[cn];
        idx_r <= idx_r + UsedW'(1);
      end
      if (cmd.drop_top) begin
        used_r <= used_r - UsedW'(1);
        exp_r[ct] <= 1'b0;
        idx_r <= '0;
      end
    end
  end

  // Table payload.
  always_ff @(posedge clk) begin
    if (creating) begin
      id_r[ci] <= next_id_r;
      grp_r[ci] <= q_grp_r;
      first_r[ci] <= q_tt_r;
      lat_r[ci] <= q_tt_r;
      start_r[ci] <= q_bt_r;
      stop_r[ci] <= q_et_r;
      rdy_r[ci] <= q_rdy_r;
      tc_r[ci] <= CntW'(1);
      rc_r[ci] <= '0;
      seen_r[ci] <= bit_sel;
    end
    if (merging) begin
      if (q_tt_r > lat_r[ci]) lat_r[ci] <= q_tt_r;
      if (q_bt_r < start_r[ci]) start_r[ci] <= q_bt_r;
      if (q_et_r > stop_r[ci]) stop_r[ci] <= q_et_r;
      if (q_rdy_r > rdy_r[ci]) rdy_r[ci] <= q_rdy_r;
      tc_r[ci] <= m_tc;
      rc_r[ci] <= m_rc;
      seen_r[ci] <= seen_r[ci] | bit_sel;
    end
    if (cmd.shift) begin
      id_r[ci] <= id_r[cn];
      grp_r[ci] <= grp_r[cn];
      first_r[ci] <= first_r[cn];
      lat_r[ci] <= lat_r[cn];
      start_r[ci] <= start_r[cn];
      stop_r[ci] <= stop_r[cn];
      rdy_r[ci] <= rdy_r[cn];
      tc_r[ci] <= tc_r[cn];
      rc_r[ci] <= rc_r[cn];
      seen_r[ci] <= seen_r[cn];
    end
  end

  // Result register; a merge or create reports the entry after update.
  logic emit_any;
  assign emit_any = cmd.emit || list_emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (emit_any || cmd.emit_none) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Is this the last list hit: no later hit and not 16 reached is resolved by lookahead.
  logic list_more;
  always_comb begin
    list_more = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if (k > int'(idx_r) && k < int'(used_r) && !exp_r[k] &&
          (q_all_r || q_now_r >= rdy_r[k])) list_more = 1'b1;
    end
  end
  logic [4:0] lcnt_r;
  always_ff @(posedge clk) begin
    if (cmd.load) lcnt_r <= '0;
    else if (list_emit) lcnt_r <= lcnt_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_none) begin
      res_status <= (sts.full && q_mode_r == MODE_REG) ? ST_FULL : ST_NONE;
      res_id <= '0; res_group <= '0;
      res_first <= '0; res_latest <= '0; res_start <= '0;
      res_stop <= '0; res_ready <= '0;
      res_tcnt <= '0; res_rcnt <= '0;
      res_last <= 1'b1;
    end else if (emit_any) begin
      res_status <= ST_ENTRY;
      res_id <= creating ? next_id_r : id_r[ci];
      res_group <= creating ? q_grp_r : grp_r[ci];
      res_first <= creating ? q_tt_r : first_r[ci];
      res_latest <= creating ? q_tt_r :
                    (merging && q_tt_r > lat_r[ci]) ? q_tt_r : lat_r[ci];
      res_start <= creating ? q_bt_r :
                   (merging && q_bt_r < start_r[ci]) ? q_bt_r : start_r[ci];
      res_stop <= creating ? q_et_r :
                  (merging && q_et_r > stop_r[ci]) ? q_et_r : stop_r[ci];
      res_ready <= creating ? q_rdy_r :
                   (merging && q_rdy_r > rdy_r[ci]) ? q_rdy_r : rdy_r[ci];
      res_tcnt <= creating ? CntW'(1) : merging ? m_tc : tc_r[ci];
      res_rcnt <= creating ? '0 : merging ? m_rc : rc_r[ci];
      res_last <= list_emit ? (!list_more || lcnt_r == 5'd15) : cmd.out_last;
    end
  end

  // A created entry always lands at the end of the packed region.
  assert property (@(posedge clk) disable iff (!rst_n)
    creating |-> (idx_r == used_r) && (used_r < UsedW'(TABLE_DEPTH)))
    else $error("create beyond table");
  assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UsedW'(TABLE_DEPTH)) else $error("used count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (emit_any || cmd.emit_none) |-> !(out_valid && !out_take))
    else $error("result overwritten");

endmodule

// ===== design/trigger_window_coalescer_top.sv =====
// Top level of the trigger window coalescer.
// Requests are taken one at a time: in_tready is high only while the controller
// idles. A register, mark or list request then walks the packed event table one
// entry per cycle while the output is not stalled, and the next request can be
// accepted once the walk has ended. A remove reports the oldest match at once,
// then copies every entry behind it down by one per cycle, drops the top entry
// and rescans from the head, repeating this for every matching entry. Any
// result waits while out_tvalid is high and out_tready is low. Register
// requests merge into the oldest matching unexported entry or create a new
// one; requests of the snapshot group never merge. List requests return up
// to sixteen ready entries (all unexported ones with the list-all flag)
// oldest first, with tlast on the final one.
`timescale 1ns / 1ps
module trigger_window_coalescer_top
  import twc_pkg::*;
#(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int NUM_TRIGGER_IDS = NumTriggerIdsDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data,       // snapshot group [2:0]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,       // mode [1:0]
  // group, trigger id, fire time, window begin, window end, cooldown,
  // present time, list-all flag, target id (low to high)
  input  logic [263:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,      // status [1:0]
  // entry id, entry group, first fire, latest fire, window start,
  // window stop, ready time, trigger count, repeat count (low to high)
  output logic [295:0] out_tdata,
  output logic         out_tlast
);

  logic [GrpW-1:0] snap_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) snap_r <= '0;
    else if (cfg_valid) snap_r <= cfg_data[GrpW-1:0];
  end

  twc_cmd_t cmd;
  twc_sts_t sts;
  logic in_fire, out_take;
  assign in_fire = in_tvalid && in_tready;
  assign out_take = out_tvalid && out_tready;

  twc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire),
    .mode(mode_t'(in_tuser)), .sts(sts),
    .out_busy(out_tvalid && !out_tready),
    .in_ready(in_tready), .cmd(cmd)
  );

  logic [1:0] r_st;
  logic [IdW-1:0] r_id;
  logic [GrpW-1:0] r_grp;
  logic [TimeBits-1:0] r_f, r_l, r_s, r_e, r_r;
  logic [CntW-1:0] r_tc, r_rc;

  twc_dp #(.TABLE_DEPTH(TABLE_DEPTH), .NUM_TRIGGER_IDS(NUM_TRIGGER_IDS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .snapshot_group(snap_r),
    .mode(mode_t'(in_tuser)), .group(in_tdata[2:0]),
    .trigger_id(in_tdata[6:3]),
    .fire_tm(in_tdata[54:7]),
    .win_beg(in_tdata[102:55]),
    .win_end(in_tdata[150:103]),
    .cool_tm(in_tdata[198:151]),
    .now_tm(in_tdata[246:199]),
    .list_all(in_tdata[247]), .target_id(in_tdata[263:248]),
    .out_take(out_take), .out_valid(out_tvalid),
    .res_status(r_st), .res_id(r_id), .res_group(r_grp),
    .res_first(r_f), .res_latest(r_l), .res_start(r_s), .res_stop(r_e),
    .res_ready(r_r), .res_tcnt(r_tc), .res_rcnt(r_rc), .res_last(out_tlast)
  );

  assign out_tuser = r_st;
  assign out_tdata = {5'd0, r_rc, r_tc, r_r, r_e, r_s, r_l, r_f, r_grp, r_id};

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the trigger window coalescer top level.
`timescale 1ns / 1ps
module tb_top;
  import twc_pkg::*;

  localparam int Depth = 16;
  localparam int MaxRes = 16;
  localparam int Settle = 40;
  localparam int WatchLimit = 20000;
  localparam logic [47:0] TMax = '1;

  typedef enum logic [1:0] {
    K_ITEM,
    K_CFG,
    K_DRAIN
  } step_kind_t;

  typedef struct {
    step_kind_t kind;
    logic [2:0] cfg;
    mode_t mode;
    logic [2:0] grp;
    logic [3:0] tid;
    logic [47:0] tt, bt, et, cd, now;
    logic all;
    logic [15:0] target;
  } step_t;

  typedef struct {
    status_t st;
    logic [15:0] id;
    logic [2:0] grp;
    logic [47:0] ff, lf, ws, we, rt;
    logic [15:0] tc, rc;
    logic last;
  } event_rpt_t;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [1:0] in_tuser = '0;
  logic [263:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [1:0] out_tuser;
  logic [295:0] out_tdata;
  logic out_tlast;

  step_t pending[$];
  event_rpt_t expected_rpts[$];
  int errors = 0;
  int items_sent = 0;
  int rpts_checked = 0;
  int cfg_writes = 0;
  bit stim_done = 0;

  // Shadow copy of the event table.
  logic [2:0] snap_grp;
  int used;
  logic ev_exp[Depth];
  logic [15:0] ev_id[Depth];
  logic [2:0] ev_grp[Depth];
  logic [47:0] ev_first[Depth], ev_lat[Depth], ev_start[Depth], ev_stop[Depth];
  logic [47:0] ev_ready[Depth];
  logic [15:0] ev_tc[Depth], ev_rc[Depth], ev_seen[Depth];
  logic [15:0] next_id;

  trigger_window_coalescer_top u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tuser(out_tuser),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  function automatic event_rpt_t none_rpt(status_t st);
    event_rpt_t r;
    r = '{st: st, id: 0, grp: 0, ff: 0, lf: 0, ws: 0, we: 0, rt: 0, tc: 0, rc: 0,
          last: 1'b1};
    return r;
  endfunction

  function automatic event_rpt_t entry_rpt(int e, logic last);
    event_rpt_t r;
    r = '{st: ST_ENTRY, id: ev_id[e], grp: ev_grp[e], ff: ev_first[e], lf: ev_lat[e],
          ws: ev_start[e], we: ev_stop[e], rt: ev_ready[e], tc: ev_tc[e], rc: ev_rc[e],
          last: last};
    return r;
  endfunction

  // Apply one accepted request to the shadow table and queue its reports.
  task automatic coalesce_request(step_t s);
    logic [48:0] sum;
    logic [47:0] rdy;
    logic [15:0] bit_m;
    int k, w;
    bit done, found;
    done = 0;
    case (s.mode)
      MODE_REG: begin
        sum = {1'b0, s.et} + {1'b0, s.cd};
        rdy = sum[48] ? TMax : sum[47:0];
        bit_m = 16'd1 << s.tid;
        if (s.grp != snap_grp) begin
          for (int i = 0; i < used && !done; i++) begin
            if (!ev_exp[i] && ev_grp[i] == s.grp && s.et >= ev_start[i] &&
                (s.bt <= ev_stop[i] || s.tt <= ev_ready[i])) begin
              if (s.tt > ev_lat[i]) ev_lat[i] = s.tt;
              if (s.bt < ev_start[i]) ev_start[i] = s.bt;
              if (s.et > ev_stop[i]) ev_stop[i] = s.et;
              if (rdy > ev_ready[i]) ev_ready[i] = rdy;
              if (ev_tc[i] != CntMax) ev_tc[i]++;
              if ((ev_seen[i] & bit_m) != 0 && ev_rc[i] != CntMax) ev_rc[i]++;
              ev_seen[i] |= bit_m;
              expected_rpts.push_back(entry_rpt(i, 1'b1));
              done = 1;
            end
          end
        end
        if (!done) begin
          if (used >= Depth) begin
            expected_rpts.push_back(none_rpt(ST_FULL));
          end else begin
            ev_exp[used] = 0;
            ev_id[used] = next_id;
            next_id++;
            ev_grp[used] = s.grp;
            ev_first[used] = s.tt;
            ev_lat[used] = s.tt;
            ev_start[used] = s.bt;
            ev_stop[used] = s.et;
            ev_ready[used] = rdy;
            ev_tc[used] = 1;
            ev_rc[used] = 0;
            ev_seen[used] = bit_m;
            expected_rpts.push_back(entry_rpt(used, 1'b1));
            used++;
          end
        end
      end
      MODE_LIST: begin
        k = 0;
        for (int i = 0; i < used && k < MaxRes; i++) begin
          if (!ev_exp[i] && (s.all || s.now >= ev_ready[i])) begin
            expected_rpts.push_back(entry_rpt(i, 1'b0));
            k++;
          end
        end
        if (k == 0) expected_rpts.push_back(none_rpt(ST_NONE));
        else expected_rpts[$].last = 1'b1;
      end
      MODE_MARK: begin
        for (int i = 0; i < used && !done; i++) begin
          if (ev_id[i] == s.target) begin
            ev_exp[i] = 1;
            expected_rpts.push_back(entry_rpt(i, 1'b1));
            done = 1;
          end
        end
        if (!done) expected_rpts.push_back(none_rpt(ST_NONE));
      end
      default: begin
        w = 0;
        found = 0;
        for (int i = 0; i < used; i++) begin
          if (ev_id[i] == s.target) begin
            if (!found) expected_rpts.push_back(entry_rpt(i, 1'b1));
            found = 1;
          end else begin
            ev_exp[w] = ev_exp[i]; ev_id[w] = ev_id[i]; ev_grp[w] = ev_grp[i];
            ev_first[w] = ev_first[i]; ev_lat[w] = ev_lat[i];
            ev_start[w] = ev_start[i]; ev_stop[w] = ev_stop[i];
            ev_ready[w] = ev_ready[i]; ev_tc[w] = ev_tc[i]; ev_rc[w] = ev_rc[i];
            ev_seen[w] = ev_seen[i];
            w++;
          end
        end
        used = w;
        if (!found) expected_rpts.push_back(none_rpt(ST_NONE));
      end
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [47:0] rnd_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 48'($urandom_range(0, 300));
    if (r < 92) return 48'({$urandom, $urandom});
    if (r < 96) return TMax;
    return 48'd0;
  endfunction

  function automatic step_t mk(mode_t m, logic [2:0] g, logic [3:0] tid,
                               logic [47:0] tt, logic [47:0] bt, logic [47:0] et,
                               logic [47:0] cd, logic [47:0] now, logic all,
                               logic [15:0] tgt);
    step_t s;
    s = '{kind: K_ITEM, cfg: 0, mode: m, grp: g, tid: tid, tt: tt, bt: bt, et: et,
          cd: cd, now: now, all: all, target: tgt};
    return s;
  endfunction

  function automatic step_t mk_cfg(step_kind_t k, logic [2:0] v);
    step_t s;
    s = mk(MODE_LIST, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    s.kind = k;
    s.cfg = v;
    return s;
  endfunction

  // Driver: requests and configuration writes from the pending queue.
  int gap = 0;
  int quiet = 0;
  always @(posedge clk) begin
    step_t p;
    logic busy, cbusy;
    if (!rst_n) begin
      in_tvalid <= 0;
      cfg_valid <= 0;
    end else begin
      busy = in_tvalid;
      cbusy = cfg_valid;
      if (in_tvalid && in_tready) begin
        p = pending.pop_front();
        coalesce_request(p);
        items_sent++;
        busy = 0;
      end
      if (cfg_valid && cfg_ready) begin
        p = pending.pop_front();
        snap_grp = p.cfg;
        cfg_writes++;
        cbusy = 0;
      end
      quiet = (expected_rpts.size() == 0) ? quiet + 1 : 0;
      if (!busy && !cbusy) begin
        if (gap > 0) begin
          gap--;
        end else if (pending.size() > 0) begin
          p = pending[0];
          if (p.kind == K_ITEM) begin
            in_tuser <= p.mode;
            in_tdata <= {p.target, p.all, p.now, p.cd, p.et, p.bt, p.tt,
                         p.tid, p.grp};
            busy = 1;
            gap = pick_gap();
          end else if (quiet >= Settle && !out_tvalid && in_tready) begin
            if (p.kind == K_CFG) begin
              cfg_data <= {5'b0, p.cfg};
              cbusy = 1;
            end else begin
              void'(pending.pop_front());
            end
          end
        end
      end
      in_tvalid <= busy;
      cfg_valid <= cbusy;
    end
  end

  // Monitor: random back-pressure, report checking and the watchdog.
  int stall = 0;
  int idle_cycles = 0;
  always @(posedge clk) begin
    event_rpt_t e;
    logic [295:0] a;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (cfg_valid && cfg_ready) ||
          (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("Watchdog expired with %0d reports outstanding", expected_rpts.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        a = out_tdata;
        if (expected_rpts.size() == 0) begin
          $error("report with no request outstanding");
          errors++;
        end else begin
          e = expected_rpts.pop_front();
          rpts_checked++;
          if (out_tuser != e.st) begin
            $error("status exp %0d act %0d", e.st, out_tuser); errors++;
          end
          if (a[15:0] != e.id) begin
            $error("entry_id exp %0d act %0d", e.id, a[15:0]); errors++;
          end
          if (a[18:16] != e.grp) begin
            $error("entry_group exp %0d act %0d", e.grp, a[18:16]); errors++;
          end
          if (a[66:19] != e.ff) begin
            $error("first_fire exp %0h act %0h", e.ff, a[66:19]); errors++;
          end
          if (a[114:67] != e.lf) begin
            $error("latest_fire exp %0h act %0h", e.lf, a[114:67]); errors++;
          end
          if (a[162:115] != e.ws) begin
            $error("window_start exp %0h act %0h", e.ws, a[162:115]); errors++;
          end
          if (a[210:163] != e.we) begin
            $error("window_stop exp %0h act %0h", e.we, a[210:163]); errors++;
          end
          if (a[258:211] != e.rt) begin
            $error("ready_time exp %0h act %0h", e.rt, a[258:211]); errors++;
          end
          if (a[274:259] != e.tc) begin
            $error("trigger_count exp %0d act %0d", e.tc, a[274:259]); errors++;
          end
          if (a[290:275] != e.rc) begin
            $error("repeat_count exp %0d act %0d", e.rc, a[290:275]); errors++;
          end
          if (out_tlast != e.last) begin
            $error("last exp %0d act %0d", e.last, out_tlast); errors++;
          end
        end
      end
      if (stall > 0) begin
        stall--;
        out_tready <= 0;
      end else begin
        out_tready <= 1;
        if ($urandom_range(0, 99) < 30) stall = pick_gap();
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int regs, r;
    logic [47:0] b;
    snap_grp = 0;
    used = 0;
    next_id = 0;
    regs = 0;
    // Directed: empty table, extremes, merges, snapshot group and a full table.
    pending.push_back(mk_cfg(K_CFG, 3'd0));
    pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, TMax, 1, 0));
    pending.push_back(mk(MODE_MARK, 0, 0, 0, 0, 0, 0, 0, 0, 16'hFFFF));
    pending.push_back(mk(MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 16'h0000));
    pending.push_back(mk(MODE_REG, 7, 15, TMax, TMax, TMax, TMax, 0, 0, 0));
    pending.push_back(mk(MODE_REG, 1, 3, 10, 5, 20, 30, 0, 0, 0));
    pending.push_back(mk(MODE_REG, 1, 3, 12, 18, 25, 5, 0, 0, 0));
    pending.push_back(mk(MODE_REG, 1, 4, 40, 30, 60, 0, 0, 0, 0));
    pending.push_back(mk(MODE_REG, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(MODE_REG, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, 40, 0, 0));
    pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, TMax, 0, 0));
    pending.push_back(mk(MODE_MARK, 0, 0, 0, 0, 0, 0, 0, 0, 16'd1));
    pending.push_back(mk(MODE_REG, 1, 3, 12, 18, 25, 5, 0, 0, 0));
    pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    pending.push_back(mk(MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 16'd2));
    for (int i = 0; i < 14; i++)
      pending.push_back(mk(MODE_REG, 3'(i % 6 + 2), 4'(i), 48'(i * 1000),
                           48'(i * 1000), 48'(i * 1000 + 1), 0, 0, 0, 0));
    pending.push_back(mk(MODE_REG, 6, 9, 99999, 99999, 99999, 0, 0, 0, 0));
    pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    regs = 22;
    pending.push_back(mk_cfg(K_DRAIN, 0));
    for (int i = 0; i < 18; i++)
      pending.push_back(mk(MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0, 16'(i)));
    // Random: register requests for about half of the steps, mostly with small times so merges happen.
    for (int n = 0; n < 220; n++) begin
      if (n == 55) pending.push_back(mk_cfg(K_CFG, 3'd7));
      if (n == 110) pending.push_back(mk_cfg(K_CFG, 3'd3));
      if (n == 165) pending.push_back(mk_cfg(K_CFG, 3'd0));
      r = $urandom_range(0, 99);
      if (r < 50) begin
        b = rnd_time();
        pending.push_back(mk(MODE_REG, 3'($urandom_range(0, 7)), 4'($urandom),
                             rnd_time(), b, b + 48'($urandom_range(0, 50)),
                             rnd_time(), 0, 0, 0));
        regs++;
      end else if (r < 65) begin
        pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, rnd_time(), 1'($urandom), 0));
      end else if (r < 78) begin
        pending.push_back(mk(MODE_MARK, 0, 0, 0, 0, 0, 0, 0, 0,
                             ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, regs + 1))));
      end else begin
        pending.push_back(mk(MODE_REMOVE, 0, 0, 0, 0, 0, 0, 0, 0,
                             ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                             16'($urandom_range(0, regs + 1))));
      end
    end
    pending.push_back(mk(MODE_LIST, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    repeat (2) @(posedge clk);
    rst_n <= 1;
    wait (pending.size() == 0 && !in_tvalid && !cfg_valid && expected_rpts.size() == 0);
    repeat (60) @(posedge clk);
    if (expected_rpts.size() != 0) begin
      $error("%0d expected reports never arrived", expected_rpts.size());
      errors++;
    end
    $display("Sent %0d requests across %0d snapshot group settings; %0d reports checked.",
             items_sent, cfg_writes, rpts_checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
